@@ rtl/cfme_pkg.sv @@
package cfme_pkg;

   localparam int MAX_SECTIONS_DEFAULT = 8;
   localparam int MAX_TERMS_DEFAULT    = 10;

   // fraction bits of normalized coordinates and Chebyshev terms
   localparam int NFR       = 26;
   localparam int T_ONE_INT = 1 << NFR;

   localparam int U_W     = 28;
   localparam int P_W     = 36;
   localparam int ACC_W   = 40;
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = 68;

   // bound words plus one word for the packed term orders
   localparam int WORDS_PER_SECTION = 7;

   localparam logic [1:0] OP_QUERY  = 2'd0;
   localparam logic [1:0] OP_BOUND  = 2'd1;
   localparam logic [1:0] OP_ORDERS = 2'd2;
   localparam logic [1:0] OP_COEF   = 2'd3;

   localparam logic [2:0] WORD_ZMIN   = 3'd0;
   localparam logic [2:0] WORD_ZMAX   = 3'd1;
   localparam logic [2:0] WORD_ZMID   = 3'd2;
   localparam logic [2:0] WORD_ZNORM  = 3'd3;
   localparam logic [2:0] WORD_RMID   = 3'd4;
   localparam logic [2:0] WORD_RNORM  = 3'd5;
   localparam logic [2:0] WORD_ORDERS = 3'd6;

   typedef struct packed {
      logic [1:0]         opcode;
      logic               component;
      logic [2:0]         section_index;
      logic [2:0]         word_select;
      logic [3:0]         coef_row;
      logic [3:0]         coef_col;
      logic signed [31:0] write_value;
      logic [3:0]         z_order;
      logic [3:0]         r_order;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic               is_query;
      logic signed [31:0] field_x;
      logic signed [31:0] field_y;
      logic signed [31:0] field_z;
      logic               radial_found;
      logic               axial_found;
      logic               saturated;
   } rsp_type;

   // v / 2^NFR rounded to nearest, ties toward +infinity
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] half;
      logic signed [PROD_W-1:0] sum;
      half = PROD_W'(1 << (NFR - 1));
      sum  = v + half;
      return sum >>> NFR;
   endfunction

endpackage

@@ rtl/chebyshev_field_map_eval.sv @@
// Sectioned 2-D Chebyshev field map evaluator.
// Requests enter on req_data when start is high and busy is low. Opcodes 1..3
// load section bounds, term orders (which also enable the section) and
// coefficients; a query (opcode 0) evaluates the radial and axial field at
// (pos_x, pos_y, pos_z). Every request gives exactly one response on rsp_data,
// shown for one cycle with rsp_strobe; the receiver cannot stall it.
// A load request is written in its accept cycle and acknowledged in the next.
// A query runs through one shared multiplier, one shared shift-subtract
// divider and a bit-serial square root, with the bound and coefficient tables
// in two synchronous memories with one write and one read port, so it is
// sequential: the radius first, then per component the section search, the
// bound reads, normalization and term recursion and the coefficient
// multiply-accumulate, plus the x/y split when r is nonzero. It takes no new
// request until it is through; with full 10x10 tables the coefficient loop
// takes the largest share of the time.
// busy stays high until the response cycle is over. Reset clears the state
// machine and the section enables; bounds and coefficients are not cleared.
module chebyshev_field_map_eval
   import cfme_pkg::*;
#(
   parameter int MAX_SECTIONS = MAX_SECTIONS_DEFAULT,
   parameter int MAX_TERMS    = MAX_TERMS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int VI_W       = $clog2(2 * MAX_SECTIONS);
   localparam int TW         = $clog2(MAX_TERMS);
   localparam int BND_DEPTH  = 2 * MAX_SECTIONS * WORDS_PER_SECTION;
   localparam int BA_W       = $clog2(BND_DEPTH);
   localparam int COEF_DEPTH = 2 * MAX_SECTIONS * MAX_TERMS * MAX_TERMS;
   localparam int CA_W       = $clog2(COEF_DEPTH);
   localparam logic [3:0] ORD_MAX = 4'(MAX_TERMS - 1);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_ACK     = 5'd1;
   localparam logic [4:0] ST_SQ_X    = 5'd2;
   localparam logic [4:0] ST_SQ_Y    = 5'd3;
   localparam logic [4:0] ST_SQ_SUM  = 5'd4;
   localparam logic [4:0] ST_SQ_IT   = 5'd5;
   localparam logic [4:0] ST_SR_A    = 5'd6;
   localparam logic [4:0] ST_SR_B    = 5'd7;
   localparam logic [4:0] ST_SR_C    = 5'd8;
   localparam logic [4:0] ST_LD      = 5'd9;
   localparam logic [4:0] ST_NRM     = 5'd10;
   localparam logic [4:0] ST_NDIV    = 5'd11;
   localparam logic [4:0] ST_CH_INIT = 5'd12;
   localparam logic [4:0] ST_CH_MUL  = 5'd13;
   localparam logic [4:0] ST_CH_ACC  = 5'd14;
   localparam logic [4:0] ST_M_RD    = 5'd15;
   localparam logic [4:0] ST_M_MUL   = 5'd16;
   localparam logic [4:0] ST_M_ACC   = 5'd17;
   localparam logic [4:0] ST_R_MUL   = 5'd18;
   localparam logic [4:0] ST_R_ACC   = 5'd19;
   localparam logic [4:0] ST_CDONE   = 5'd20;
   localparam logic [4:0] ST_SPL_MUL = 5'd21;
   localparam logic [4:0] ST_SPL_LD  = 5'd22;
   localparam logic [4:0] ST_SDIV    = 5'd23;
   localparam logic [4:0] ST_RSP     = 5'd24;

   // control
   logic [4:0]       state_ff, state_in;
   logic             comp_ff, comp_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic [2:0]       ld_ff, ld_in;
   logic             nsel_ff, nsel_in;
   logic [TW-1:0]    k_ff, k_in;
   logic [TW-1:0]    row_ff, row_in;
   logic [TW-1:0]    col_ff, col_in;
   logic             spl_ff, spl_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [2*MAX_SECTIONS-1:0] valid_ff, valid_in;

   // datapath
   logic signed [31:0]       x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [31:0]              r_ff, r_in;
   logic signed [31:0]       lo_ff, lo_in;
   logic signed [31:0]       zmid_ff, zmid_in, znorm_ff, znorm_in;
   logic signed [31:0]       rmid_ff, rmid_in, rnorm_ff, rnorm_in;
   logic [3:0]               zo_ff, zo_in, ro_ff, ro_in;
   logic signed [U_W-1:0]    u_ff, u_in, tp1_ff, tp1_in, tp2_ff, tp2_in;
   logic signed [U_W-1:0]    tz_ff [MAX_TERMS];
   logic signed [U_W-1:0]    tr_ff [MAX_TERMS];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       br_ff, br_in, bz_ff, bz_in, fx_ff, fx_in, fy_ff, fy_in;
   logic [1:0]               found_ff, found_in;
   logic                     sat_ff, sat_in;
   logic [31:0]              dv_rem_ff, dv_rem_in, dv_q_ff, dv_q_in, dv_den_ff, dv_den_in;
   logic                     dv_neg_ff, dv_neg_in;
   logic [63:0]              sq_v_ff, sq_v_in;
   logic [33:0]              sq_rem_ff, sq_rem_in;
   logic [31:0]              sq_root_ff, sq_root_in;

   // memories
   logic [31:0] bnd_mem  [BND_DEPTH];
   logic [31:0] coef_mem [COEF_DEPTH];
   logic [31:0] bnd_rd_ff, coef_rd_ff;
   logic [BA_W-1:0] bnd_raddr, bnd_waddr;
   logic [CA_W-1:0] coef_raddr, coef_waddr;
   logic [2:0]      bnd_word, bnd_wword;
   logic [31:0]     bnd_wdata;
   logic            bnd_we, coef_we;

   logic            accept, wr_ok;
   logic [3:0]      zo_clip, ro_clip;
   logic [VI_W-1:0] vidx, widx;
   logic            sec_last;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  rs, cheb_raw;
   logic signed [U_W-1:0]     cheb_new;

   logic signed [33:0] nrm_num;
   logic signed [31:0] nrm_den;
   logic [33:0]        nrm_mn;
   logic [31:0]        nrm_md;
   logic               nrm_neg;

   logic [32:0] dv_sh;
   logic        dv_ge;
   logic [31:0] dv_rem_nx, dv_q_nx;

   logic [35:0] sq_sh, sq_trial;
   logic        sq_ge;
   logic [33:0] sq_rem_nx;
   logic [31:0] sq_root_nx;

   logic [PROD_W-1:0]  spl_mag;
   logic signed [31:0] comp_val;
   logic               comp_clip;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = (state_ff == ST_ACK) || (state_ff == ST_RSP);

   always_comb begin
      rsp_data = '0;
      if (state_ff == ST_RSP) begin
         rsp_data.is_query     = 1'b1;
         rsp_data.field_x      = fx_ff;
         rsp_data.field_y      = fy_ff;
         rsp_data.field_z      = bz_ff;
         rsp_data.radial_found = found_ff[0];
         rsp_data.axial_found  = found_ff[1];
         rsp_data.saturated    = sat_ff;
      end
   end

   // ---------------- load path ----------------
   assign wr_ok   = accept && (req_data.opcode != OP_QUERY) &&
                    (int'(req_data.section_index) < MAX_SECTIONS);
   assign zo_clip = (req_data.z_order > ORD_MAX) ? ORD_MAX : req_data.z_order;
   assign ro_clip = (req_data.r_order > ORD_MAX) ? ORD_MAX : req_data.r_order;
   assign bnd_we  = wr_ok && (((req_data.opcode == OP_BOUND) &&
                               (req_data.word_select <= WORD_RNORM)) ||
                              (req_data.opcode == OP_ORDERS));
   assign bnd_wword = (req_data.opcode == OP_ORDERS) ? WORD_ORDERS : req_data.word_select;
   assign bnd_wdata = (req_data.opcode == OP_ORDERS) ? {24'd0, zo_clip, ro_clip}
                                                     : req_data.write_value;
   assign bnd_waddr = BA_W'((int'(req_data.component) * MAX_SECTIONS +
                             int'(req_data.section_index)) * WORDS_PER_SECTION +
                            int'(bnd_wword));
   assign coef_we   = wr_ok && (req_data.opcode == OP_COEF) &&
                      (int'(req_data.coef_row) < MAX_TERMS) &&
                      (int'(req_data.coef_col) < MAX_TERMS);
   assign coef_waddr = CA_W'(((int'(req_data.component) * MAX_SECTIONS +
                               int'(req_data.section_index)) * MAX_TERMS +
                              int'(req_data.coef_row)) * MAX_TERMS +
                             int'(req_data.coef_col));
   assign widx = VI_W'(int'(req_data.component) * MAX_SECTIONS +
                       int'(req_data.section_index));

   // ---------------- read addresses ----------------
   assign vidx     = VI_W'(int'(comp_ff) * MAX_SECTIONS + int'(sec_ff));
   assign sec_last = (sec_ff == SEC_W'(MAX_SECTIONS - 1));

   always_comb begin
      unique case (state_ff)
         ST_SR_A: bnd_word = WORD_ZMIN;
         ST_SR_B: bnd_word = WORD_ZMAX;
         ST_LD:   bnd_word = (ld_ff < 3'd5) ? 3'(ld_ff + WORD_ZMID) : WORD_ORDERS;
         default: bnd_word = WORD_ZMIN;
      endcase
   end

   assign bnd_raddr  = BA_W'((int'(comp_ff) * MAX_SECTIONS + int'(sec_ff)) *
                             WORDS_PER_SECTION + int'(bnd_word));
   assign coef_raddr = CA_W'(((int'(comp_ff) * MAX_SECTIONS + int'(sec_ff)) * MAX_TERMS +
                              int'(row_ff)) * MAX_TERMS + int'(col_ff));

   always_ff @(posedge clock) begin
      if (bnd_we) begin
         bnd_mem[bnd_waddr] <= bnd_wdata;
      end
      bnd_rd_ff <= bnd_mem[bnd_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_data.write_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   // ---------------- shared multiplier ----------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ_X: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = x_ff;
         end
         ST_SQ_Y: begin
            mul_a = MUL_A_W'(y_ff);
            mul_b = y_ff;
         end
         ST_CH_MUL: begin
            mul_a = MUL_A_W'(u_ff) <<< 1;
            mul_b = MUL_B_W'(tp1_ff);
         end
         ST_M_MUL: begin
            mul_a = MUL_A_W'($signed(coef_rd_ff));
            mul_b = MUL_B_W'(tr_ff[col_ff]);
         end
         ST_R_MUL: begin
            mul_a = p_ff;
            mul_b = MUL_B_W'(tz_ff[row_ff]);
         end
         ST_SPL_MUL: begin
            mul_a = MUL_A_W'(br_ff);
            mul_b = spl_ff ? y_ff : x_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign rs      = round_shift(prod_ff);

   // next Chebyshev term, clamped to [-1, 1]
   assign cheb_raw = rs - PROD_W'(tp2_ff);
   always_comb begin
      if (cheb_raw > PROD_W'(T_ONE_INT)) begin
         cheb_new = U_W'(T_ONE_INT);
      end else if (cheb_raw < -PROD_W'(T_ONE_INT)) begin
         cheb_new = -U_W'(T_ONE_INT);
      end else begin
         cheb_new = U_W'(cheb_raw);
      end
   end

   // ---------------- normalization operands ----------------
   assign nrm_num = nsel_ff ? ($signed({2'b00, r_ff}) - 34'(rmid_ff))
                            : (34'(z_ff) - 34'(zmid_ff));
   assign nrm_den = nsel_ff ? rnorm_ff : znorm_ff;
   assign nrm_mn  = nrm_num[33] ? 34'(-nrm_num) : 34'(nrm_num);
   assign nrm_md  = nrm_den[31] ? 32'(-nrm_den) : 32'(nrm_den);
   assign nrm_neg = nrm_num[33] ^ nrm_den[31];

   // ---------------- shift-subtract divider step ----------------
   assign dv_sh     = {dv_rem_ff, dv_q_ff[31]};
   assign dv_ge     = (dv_sh >= {1'b0, dv_den_ff});
   assign dv_rem_nx = dv_ge ? 32'(dv_sh - {1'b0, dv_den_ff}) : dv_sh[31:0];
   assign dv_q_nx   = {dv_q_ff[30:0], dv_ge};

   // ---------------- square root step ----------------
   assign sq_sh      = {sq_rem_ff, sq_v_ff[63:62]};
   assign sq_trial   = {2'b00, sq_root_ff, 2'b01};
   assign sq_ge      = (sq_sh >= sq_trial);
   assign sq_rem_nx  = sq_ge ? 34'(sq_sh - sq_trial) : sq_sh[33:0];
   assign sq_root_nx = {sq_root_ff[30:0], sq_ge};

   assign spl_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);

   always_comb begin
      comp_clip = 1'b0;
      if (acc_ff > ACC_W'(32'sh7fffffff)) begin
         comp_val  = 32'sh7fffffff;
         comp_clip = 1'b1;
      end else if (acc_ff < ACC_W'(32'sh80000000)) begin
         comp_val  = 32'sh80000000;
         comp_clip = 1'b1;
      end else begin
         comp_val  = 32'(acc_ff);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      comp_in    = comp_ff;
      sec_in     = sec_ff;
      ld_in      = ld_ff;
      nsel_in    = nsel_ff;
      k_in       = k_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      spl_in     = spl_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      r_in       = r_ff;
      lo_in      = lo_ff;
      zmid_in    = zmid_ff;
      znorm_in   = znorm_ff;
      rmid_in    = rmid_ff;
      rnorm_in   = rnorm_ff;
      zo_in      = zo_ff;
      ro_in      = ro_ff;
      u_in       = u_ff;
      tp1_in     = tp1_ff;
      tp2_in     = tp2_ff;
      p_in       = p_ff;
      acc_in     = acc_ff;
      br_in      = br_ff;
      bz_in      = bz_ff;
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      found_in   = found_ff;
      sat_in     = sat_ff;
      dv_rem_in  = dv_rem_ff;
      dv_q_in    = dv_q_ff;
      dv_den_in  = dv_den_ff;
      dv_neg_in  = dv_neg_ff;
      sq_v_in    = sq_v_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;

      if (wr_ok && (req_data.opcode == OP_ORDERS)) begin
         valid_in[widx] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_QUERY) begin
                  x_in     = req_data.pos_x;
                  y_in     = req_data.pos_y;
                  z_in     = req_data.pos_z;
                  sat_in   = 1'b0;
                  found_in = 2'b00;
                  state_in = ST_SQ_X;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_ACK: state_in = ST_IDLE;
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: begin
            sq_v_in  = prod_ff[63:0];
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            sq_v_in    = sq_v_ff + prod_ff[63:0];
            sq_rem_in  = '0;
            sq_root_in = '0;
            cnt_in     = '0;
            state_in   = ST_SQ_IT;
         end
         ST_SQ_IT: begin
            sq_v_in    = {sq_v_ff[61:0], 2'b00};
            sq_rem_in  = sq_rem_nx;
            sq_root_in = sq_root_nx;
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               r_in     = sq_root_nx;
               comp_in  = 1'b0;
               sec_in   = '0;
               acc_in   = '0;
               state_in = ST_SR_A;
            end
         end
         ST_SR_A: begin
            if (!valid_ff[vidx]) begin
               if (sec_last) begin
                  state_in = ST_CDONE;
               end else begin
                  sec_in = sec_ff + SEC_W'(1);
               end
            end else begin
               state_in = ST_SR_B;
            end
         end
         ST_SR_B: begin
            lo_in    = $signed(bnd_rd_ff);
            state_in = ST_SR_C;
         end
         ST_SR_C: begin
            if ((lo_ff <= z_ff) && (z_ff < $signed(bnd_rd_ff))) begin
               found_in[comp_ff] = 1'b1;
               ld_in             = '0;
               state_in          = ST_LD;
            end else if (sec_last) begin
               state_in = ST_CDONE;
            end else begin
               sec_in   = sec_ff + SEC_W'(1);
               state_in = ST_SR_A;
            end
         end
         ST_LD: begin
            ld_in = ld_ff + 3'd1;
            case (ld_ff)
               3'd1: zmid_in  = $signed(bnd_rd_ff);
               3'd2: znorm_in = $signed(bnd_rd_ff);
               3'd3: rmid_in  = $signed(bnd_rd_ff);
               3'd4: rnorm_in = $signed(bnd_rd_ff);
               3'd5: begin
                  zo_in    = bnd_rd_ff[7:4];
                  ro_in    = bnd_rd_ff[3:0];
                  nsel_in  = 1'b0;
                  state_in = ST_NRM;
               end
               default: ;
            endcase
         end
         ST_NRM: begin
            if (nrm_den == '0) begin
               u_in     = '0;
               sat_in   = 1'b1;
               state_in = ST_CH_INIT;
            end else if (nrm_mn >= {2'b00, nrm_md}) begin
               // at or beyond the edge: exactly +-1, clipped if beyond
               u_in = nrm_neg ? -U_W'(T_ONE_INT) : U_W'(T_ONE_INT);
               if (nrm_mn != {2'b00, nrm_md}) begin
                  sat_in = 1'b1;
               end
               state_in = ST_CH_INIT;
            end else begin
               dv_rem_in = nrm_mn[31:0];
               dv_q_in   = '0;
               dv_den_in = nrm_md;
               dv_neg_in = nrm_neg;
               cnt_in    = '0;
               state_in  = ST_NDIV;
            end
         end
         ST_NDIV: begin
            dv_rem_in = dv_rem_nx;
            dv_q_in   = dv_q_nx;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'(NFR - 1)) begin
               u_in     = dv_neg_ff ? -U_W'(dv_q_nx[NFR-1:0]) : U_W'(dv_q_nx[NFR-1:0]);
               state_in = ST_CH_INIT;
            end
         end
         ST_CH_INIT: begin
            tp2_in = U_W'(T_ONE_INT);
            tp1_in = u_ff;
            k_in   = TW'(2);
            if (MAX_TERMS > 2) begin
               state_in = ST_CH_MUL;
            end else if (!nsel_ff) begin
               nsel_in  = 1'b1;
               state_in = ST_NRM;
            end else begin
               row_in   = '0;
               col_in   = '0;
               p_in     = '0;
               state_in = ST_M_RD;
            end
         end
         ST_CH_MUL: state_in = ST_CH_ACC;
         ST_CH_ACC: begin
            tp2_in = tp1_ff;
            tp1_in = cheb_new;
            if (k_ff == TW'(MAX_TERMS - 1)) begin
               if (!nsel_ff) begin
                  nsel_in  = 1'b1;
                  state_in = ST_NRM;
               end else begin
                  row_in   = '0;
                  col_in   = '0;
                  p_in     = '0;
                  state_in = ST_M_RD;
               end
            end else begin
               k_in     = k_ff + TW'(1);
               state_in = ST_CH_MUL;
            end
         end
         ST_M_RD:  state_in = ST_M_MUL;
         ST_M_MUL: state_in = ST_M_ACC;
         ST_M_ACC: begin
            p_in = p_ff + rs[P_W-1:0];
            if (col_ff == ro_ff[TW-1:0]) begin
               state_in = ST_R_MUL;
            end else begin
               col_in   = col_ff + TW'(1);
               state_in = ST_M_RD;
            end
         end
         ST_R_MUL: state_in = ST_R_ACC;
         ST_R_ACC: begin
            acc_in = acc_ff + rs[ACC_W-1:0];
            if (row_ff == zo_ff[TW-1:0]) begin
               state_in = ST_CDONE;
            end else begin
               row_in   = row_ff + TW'(1);
               col_in   = '0;
               p_in     = '0;
               state_in = ST_M_RD;
            end
         end
         ST_CDONE: begin
            if (comp_clip) begin
               sat_in = 1'b1;
            end
            if (!comp_ff) begin
               br_in    = comp_val;
               comp_in  = 1'b1;
               sec_in   = '0;
               acc_in   = '0;
               state_in = ST_SR_A;
            end else begin
               bz_in = comp_val;
               if (r_ff == '0) begin
                  fx_in    = '0;
                  fy_in    = '0;
                  state_in = ST_RSP;
               end else begin
                  spl_in   = 1'b0;
                  state_in = ST_SPL_MUL;
               end
            end
         end
         ST_SPL_MUL: state_in = ST_SPL_LD;
         ST_SPL_LD: begin
            // quotient fits 32 bits since |x| <= r, so the high word is below r
            dv_rem_in = spl_mag[63:32];
            dv_q_in   = spl_mag[31:0];
            dv_den_in = r_ff;
            dv_neg_in = prod_ff[PROD_W-1];
            cnt_in    = '0;
            state_in  = ST_SDIV;
         end
         ST_SDIV: begin
            dv_rem_in = dv_rem_nx;
            dv_q_in   = dv_q_nx;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (!spl_ff) begin
                  fx_in    = dv_neg_ff ? 32'(-dv_q_nx) : dv_q_nx;
                  spl_in   = 1'b1;
                  state_in = ST_SPL_MUL;
               end else begin
                  fy_in    = dv_neg_ff ? 32'(-dv_q_nx) : dv_q_nx;
                  state_in = ST_RSP;
               end
            end
         end
         ST_RSP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      comp_ff    <= comp_in;
      sec_ff     <= sec_in;
      ld_ff      <= ld_in;
      nsel_ff    <= nsel_in;
      k_ff       <= k_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      spl_ff     <= spl_in;
      cnt_ff     <= cnt_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      r_ff       <= r_in;
      lo_ff      <= lo_in;
      zmid_ff    <= zmid_in;
      znorm_ff   <= znorm_in;
      rmid_ff    <= rmid_in;
      rnorm_ff   <= rnorm_in;
      zo_ff      <= zo_in;
      ro_ff      <= ro_in;
      u_ff       <= u_in;
      tp1_ff     <= tp1_in;
      tp2_ff     <= tp2_in;
      prod_ff    <= prod_in;
      p_ff       <= p_in;
      acc_ff     <= acc_in;
      br_ff      <= br_in;
      bz_ff      <= bz_in;
      fx_ff      <= fx_in;
      fy_ff      <= fy_in;
      found_ff   <= found_in;
      sat_ff     <= sat_in;
      dv_rem_ff  <= dv_rem_in;
      dv_q_ff    <= dv_q_in;
      dv_den_ff  <= dv_den_in;
      dv_neg_ff  <= dv_neg_in;
      sq_v_ff    <= sq_v_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
   end

   // term tables for z (nsel 0) and r (nsel 1)
   always_ff @(posedge clock) begin
      if (state_ff == ST_CH_INIT) begin
         if (nsel_ff) begin
            tr_ff[0] <= U_W'(T_ONE_INT);
            tr_ff[1] <= u_ff;
         end else begin
            tz_ff[0] <= U_W'(T_ONE_INT);
            tz_ff[1] <= u_ff;
         end
      end
      if (state_ff == ST_CH_ACC) begin
         if (nsel_ff) begin
            tr_ff[k_ff] <= cheb_new;
         end else begin
            tz_ff[k_ff] <= cheb_new;
         end
      end
   end

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy afterwards");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NDIV || state_ff == ST_SDIV) |-> (dv_rem_ff < dv_den_ff))
      else $error("divider remainder not below divisor");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CDONE && !found_ff[comp_ff]) |-> (acc_ff == '0))
      else $error("component without section has nonzero sum");
`endif

endmodule

@@ test/tb_chebyshev_field_map_eval.sv @@
module tb_chebyshev_field_map_eval;
   import cfme_pkg::*;

   localparam int NSEC      = 8;
   localparam int NTERM     = 10;
   localparam int CYC_LIMIT = 4000000;
   localparam int N_RANDOM  = 1880;
   localparam longint T_ONE = longint'(1) << 26;

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type ex;
   } stim_row_t;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   chebyshev_field_map_eval DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0; #10;
      clock = 1'b1; #10;
   end

   // predictor copy of the tables
   int      bound_tab [2][NSEC][6];
   int      coef_tab  [2][NSEC][NTERM][NTERM];
   int      zord_tab  [2][NSEC];
   int      rord_tab  [2][NSEC];
   bit      sec_on    [2][NSEC];
   // what the stimulus has written so far
   bit      bound_set [2][NSEC][6];
   bit      coef_set  [2][NSEC][NTERM][NTERM];

   rsp_type field_q[$];
   int      n_err = 0;
   int      cycles = 0;
   bit      idle_on = 1'b0;

   function automatic longint round26(longint v);
      return (v + (longint'(1) << 25)) >>> 26;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned rem, res, b;
      rem = v; res = 0; b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint norm_coord(longint num, longint den, inout bit sat);
      longint mn, md, q;
      if (den == 0) begin
         sat = 1'b1;
         return 0;
      end
      mn = num < 0 ? -num : num;
      md = den < 0 ? -den : den;
      if (mn > md) begin
         sat = 1'b1;
         q = T_ONE;
      end else begin
         q = (mn << 26) / md;
      end
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic void cheb_terms(longint u, output longint t[NTERM]);
      longint v;
      t[0] = T_ONE;
      t[1] = u;
      for (int k = 2; k < NTERM; k++) begin
         v = round26(2 * u * t[k-1]) - t[k-2];
         if (v > T_ONE) v = T_ONE;
         if (v < -T_ONE) v = -T_ONE;
         t[k] = v;
      end
   endfunction

   function automatic bit field_sum(int c, longint r, longint z,
                                    output longint val, inout bit sat);
      int     s;
      longint tz[NTERM];
      longint tr[NTERM];
      longint acc, p;
      val = 0;
      for (s = 0; s < NSEC; s++)
         if (sec_on[c][s] && bound_tab[c][s][0] <= z && z < bound_tab[c][s][1]) break;
      if (s >= NSEC) return 1'b0;
      cheb_terms(norm_coord(z - bound_tab[c][s][2], bound_tab[c][s][3], sat), tz);
      cheb_terms(norm_coord(r - bound_tab[c][s][4], bound_tab[c][s][5], sat), tr);
      acc = 0;
      for (int row = 0; row <= zord_tab[c][s]; row++) begin
         p = 0;
         for (int col = 0; col <= rord_tab[c][s]; col++)
            p += round26(longint'(coef_tab[c][s][row][col]) * tr[col]);
         acc += round26(p * tz[row]);
      end
      if (acc > 64'sh7fffffff) begin
         sat = 1'b1;
         acc = 64'sh7fffffff;
      end else if (acc < -64'sh80000000) begin
         sat = 1'b1;
         acc = -64'sh80000000;
      end
      val = acc;
      return 1'b1;
   endfunction

   // applies one request to the predictor tables and returns its response
   function automatic rsp_type field_eval(req_type q);
      rsp_type          o;
      longint           x, y, br, bz, r;
      longint unsigned  mx, my;
      bit               sat;
      int               zo, ro;
      o = '0;
      if (q.opcode == OP_QUERY) begin
         x = q.pos_x; y = q.pos_y;
         mx = x < 0 ? -x : x;
         my = y < 0 ? -y : y;
         r = int_sqrt(mx * mx + my * my);
         sat = 1'b0;
         o.radial_found = field_sum(0, r, q.pos_z, br, sat);
         o.axial_found  = field_sum(1, r, q.pos_z, bz, sat);
         if (r != 0) begin
            o.field_x = 32'((br * x) / r);
            o.field_y = 32'((br * y) / r);
         end
         o.field_z   = 32'(bz);
         o.is_query  = 1'b1;
         o.saturated = sat;
      end else if (q.opcode == OP_BOUND) begin
         if (q.word_select <= WORD_RNORM)
            bound_tab[q.component][q.section_index][q.word_select] = q.write_value;
      end else if (q.opcode == OP_ORDERS) begin
         zo = q.z_order > NTERM - 1 ? NTERM - 1 : q.z_order;
         ro = q.r_order > NTERM - 1 ? NTERM - 1 : q.r_order;
         zord_tab[q.component][q.section_index] = zo;
         rord_tab[q.component][q.section_index] = ro;
         sec_on[q.component][q.section_index] = 1'b1;
      end else begin
         if (q.coef_row < NTERM && q.coef_col < NTERM)
            coef_tab[q.component][q.section_index][q.coef_row][q.coef_col] = q.write_value;
      end
      return o;
   endfunction

   function automatic req_type mk(logic [1:0] op, int c, int s, int w, int row, int col,
                                  int val, int zo, int ro, int x, int y, int z);
      req_type q;
      q.opcode = op; q.component = c; q.section_index = s; q.word_select = w;
      q.coef_row = row; q.coef_col = col; q.write_value = val;
      q.z_order = zo; q.r_order = ro; q.pos_x = x; q.pos_y = y; q.pos_z = z;
      return q;
   endfunction

   function automatic void note_write(req_type q);
      if (q.opcode == OP_BOUND && q.word_select <= WORD_RNORM)
         bound_set[q.component][q.section_index][q.word_select] = 1'b1;
      if (q.opcode == OP_COEF && q.coef_row < NTERM && q.coef_col < NTERM)
         coef_set[q.component][q.section_index][q.coef_row][q.coef_col] = 1'b1;
   endfunction

   function automatic int bound_value(int w);
      int cm;
      if ($urandom_range(0, 12) == 0) return $urandom;
      case (w)
         WORD_ZMIN:  cm = $urandom_range(0, 300) - 200;
         WORD_ZMAX:  cm = $urandom_range(0, 300) - 100;
         WORD_ZMID:  cm = $urandom_range(0, 100) - 50;
         WORD_RMID:  cm = $urandom_range(0, 80);
         default: begin
            case ($urandom_range(0, 9))
               0:       return 0;
               1:       cm = -$urandom_range(1, 200);
               2:       return $urandom_range(1, 255);
               default: cm = $urandom_range(1, 200);
            endcase
         end
      endcase
      return (cm <<< 16) + $urandom_range(0, 16'hffff);
   endfunction

   function automatic int coord_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return 0;
         default: return int'($urandom) >>> $urandom_range(6, 31);
      endcase
   endfunction

   // next random request; favors loading complete sections so queries go deep
   function automatic req_type next_request();
      req_type q;
      int      c, s, w, zo, ro, pick, best, br, bc, nv;
      int      vc[$];
      int      vs[$];
      longint  lo, hi;
      c = $urandom_range(0, 1);
      s = $urandom_range(0, $urandom_range(0, 1) ? 2 : NSEC - 1);
      pick = $urandom_range(0, 99);
      q = mk(OP_QUERY, c, s, $urandom_range(0, 7), $urandom_range(0, 15),
             $urandom_range(0, 15), $urandom, $urandom_range(0, 15),
             $urandom_range(0, 15), coord_value(), coord_value(), coord_value());
      if (pick < 42) begin
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < NSEC; j++)
               if (sec_on[i][j]) begin
                  vc.push_back(i);
                  vs.push_back(j);
               end
         if (vc.size() > 0 && $urandom_range(0, 9) < 8) begin
            nv = $urandom_range(0, vc.size() - 1);
            lo = bound_tab[vc[nv]][vs[nv]][0];
            hi = bound_tab[vc[nv]][vs[nv]][1];
            case ($urandom_range(0, 9))
               0:       q.pos_z = lo;
               1:       q.pos_z = hi;
               default: if (hi > lo) q.pos_z = lo + ({$urandom, $urandom} % (hi - lo));
            endcase
         end
         return q;
      end
      if (pick < 50) begin
         q.opcode = OP_BOUND;
         q.write_value = bound_value(q.word_select);
         return q;
      end
      for (w = 0; w < 6; w++)
         if (!bound_set[c][s][w]) begin
            q.opcode = OP_BOUND;
            q.word_select = w;
            q.write_value = bound_value(w);
            return q;
         end
      if (pick < 62) begin
         q.opcode = OP_ORDERS;
         zo = q.z_order > NTERM - 1 ? NTERM - 1 : q.z_order;
         ro = q.r_order > NTERM - 1 ? NTERM - 1 : q.r_order;
         if ($urandom_range(0, 1)) begin
            zo = zo % 4;
            ro = ro % 4;
         end
         forever begin
            nv = 1;
            for (int i = 0; i <= zo; i++)
               for (int j = 0; j <= ro; j++)
                  if (!coef_set[c][s][i][j]) nv = 0;
            if (nv) break;
            if (zo == 0 && ro == 0) break;
            if (zo > 0 && (ro == 0 || $urandom_range(0, 1))) zo--;
            else ro--;
         end
         if (nv) begin
            if (zo != (q.z_order > 9 ? 9 : q.z_order)) q.z_order = zo;
            if (ro != (q.r_order > 9 ? 9 : q.r_order)) q.r_order = ro;
            return q;
         end
      end
      q.opcode = OP_COEF;
      q.write_value = int'($urandom) >>> $urandom_range(0, 31);
      if ($urandom_range(0, 9) < 8) begin
         // fill the lowest missing shell first
         best = NTERM; br = 0; bc = 0;
         for (int i = 0; i < NTERM; i++)
            for (int j = 0; j < NTERM; j++)
               if (!coef_set[c][s][i][j] && (i > j ? i : j) < best) begin
                  best = i > j ? i : j;
                  br = i;
                  bc = j;
               end
         if (best < NTERM) begin
            q.coef_row = br;
            q.coef_col = bc;
         end
      end
      return q;
   endfunction

   task automatic send(req_type q, bit typed, rsp_type ex);
      rsp_type p;
      int      gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_data = q;
      do @(posedge clock); while (busy);
      p = field_eval(q);
      field_q.push_back(typed ? ex : p);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (field_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic check_field(string nm, longint e, longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", nm, e, a);
         n_err++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (field_q.size() == 0) begin
            $error("response with no request outstanding");
            n_err++;
         end else begin
            e = field_q.pop_front();
            check_field("is_query", e.is_query, rsp_data.is_query);
            check_field("field_x", e.field_x, rsp_data.field_x);
            check_field("field_y", e.field_y, rsp_data.field_y);
            check_field("field_z", e.field_z, rsp_data.field_z);
            check_field("radial_found", e.radial_found, rsp_data.radial_found);
            check_field("axial_found", e.axial_found, rsp_data.axial_found);
            check_field("saturated", e.saturated, rsp_data.saturated);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_t dir[$];
      stim_row_t rw;
      rsp_type   ack;
      rsp_type   empty_q;
      ack = '0;
      empty_q = '0;
      empty_q.is_query = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < NSEC; j++) sec_on[i][j] = 1'b0;

      // nothing enabled yet: queries see no section
      dir.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh7fffffff,
                         32'sh80000000, 0), 1, empty_q});
      dir.push_back('{mk(OP_QUERY, 1, 7, 7, 15, 15, -1, 15, 15, 0, 0,
                         32'sh80000000), 1, empty_q});
      // ignored writes: bad word select, coefficient index out of range
      dir.push_back('{mk(OP_BOUND, 1, 7, 7, 0, 0, -1, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_COEF, 1, 7, 0, 15, 15, -1, 0, 0, 0, 0, 0), 1, ack});
      // radial section 0 over z in [-100, 100) cm
      dir.push_back('{mk(OP_BOUND, 0, 0, WORD_ZMIN, 0, 0, -100 <<< 16, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 0, 0, WORD_ZMAX, 0, 0, 100 <<< 16, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 0, 0, WORD_ZMID, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 0, 0, WORD_ZNORM, 0, 0, 100 <<< 16, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 0, 0, WORD_RMID, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 0, 0, WORD_RNORM, 0, 0, 50 <<< 16, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_COEF, 0, 0, 0, 0, 0, 1 <<< 24, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_ORDERS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 3 <<< 16, 4 <<< 16, 0), 0, ack});
      // upper bound is exclusive
      dir.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 3 <<< 16, 4 <<< 16,
                         100 <<< 16), 0, ack});
      // zero radius
      dir.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, ack});
      // lower bound inclusive, radius far past rnorm
      dir.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh7fffffff,
                         32'sh7fffffff, -100 <<< 16), 0, ack});
      // axial section 0 spans every z below the largest value, with a zero z norm
      dir.push_back('{mk(OP_BOUND, 1, 0, WORD_ZMIN, 0, 0, 32'sh80000000, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 1, 0, WORD_ZMAX, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 1, 0, WORD_ZMID, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 1, 0, WORD_ZNORM, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 1, 0, WORD_RMID, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_BOUND, 1, 0, WORD_RNORM, 0, 0, 1, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_COEF, 1, 0, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_ORDERS, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack});
      dir.push_back('{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, -1, 1, 32'sh80000000), 0, ack});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir[i]) begin
         rw = dir[i];
         note_write(rw.rq);
         send(rw.rq, rw.typed, rw.ex);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         req_type q;
         if (n % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
         if (n == N_RANDOM / 2) drain();
         q = next_request();
         note_write(q);
         send(q, 1'b0, ack);
      end
      start = 1'b0;

      while (field_q.size() > 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (n_err == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
